FILE: rtl/core/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and codes for the voice slot allocator: command and status
// codes, search group size and the free-slot search result.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Status codes returned with every result
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_FULL        = 2'd1;
  localparam logic [1:0] STAT_EMPTY       = 2'd2;
  localparam logic [1:0] STAT_NOT_ON_LIST = 2'd3;

  // Slots examined per search step
  localparam int unsigned GROUP   = 32;
  localparam int unsigned GROUP_W = 5;

  // Outcome of one search step
  typedef struct packed {
    logic               found;
    logic [GROUP_W-1:0] pos;
  } scan_result_t;

endpackage

FILE: rtl/core/vsa_link_ram.sv
// ----------------------------------------------------------------------------
// vsa_link_ram
// Simple dual-port link store: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module vsa_link_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/vsa_free_scan.sv
// ----------------------------------------------------------------------------
// vsa_free_scan
// Free-slot search unit: looks at one group of slots per step and returns
// the lowest free slot in that group, if any.
// ----------------------------------------------------------------------------
module vsa_free_scan #(
  parameter  int unsigned SLOTS  = 64,
  localparam int unsigned NGRP   = (SLOTS + vsa_pkg::GROUP - 1) / vsa_pkg::GROUP,
  localparam int unsigned GRP_IW = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  logic [SLOTS-1:0]            busy,
  input  logic [GRP_IW-1:0]           grp,
  output vsa_pkg::scan_result_t       result
);

  logic [NGRP*vsa_pkg::GROUP-1:0] padded;
  logic [vsa_pkg::GROUP-1:0]      free_bits;

  // Slots past the end of the pool look busy
  always_comb begin
    padded            = '1;
    padded[SLOTS-1:0] = busy;
    free_bits         = ~padded[grp*vsa_pkg::GROUP +: vsa_pkg::GROUP];
  end

  // Lowest free slot in the group
  always_comb begin
    result.found = |free_bits;
    result.pos   = '0;
    for (int i = vsa_pkg::GROUP - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        result.pos = vsa_pkg::GROUP_W'(i);
      end
    end
  end

endmodule

FILE: rtl/core/voice_slot_allocator_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// voice_slot_allocator_ordered_list_unit
// Voice slot pool with an occupied list kept in order of acquisition.
// ----------------------------------------------------------------------------
// One request is handled at a time; tready is high only while the block is
// idle, and the result sits in an output register so the next request can be
// taken while it waits. Acquire walks the free-slot search one 32-slot group
// per step in ST_SCAN until it finds the lowest free slot, then links it in
// ST_ACQ_LINK. Release and query pass through a read state and a fix state
// because the link RAM has a registered read port. Clear and every error case
// go from accept straight to ST_RESP. No clearing pass follows reset: link
// words are only read for occupied slots, and those were written on acquire.
// ----------------------------------------------------------------------------
module voice_slot_allocator_ordered_list_unit #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request: [1:0] command, [7:2] slot
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // result: [1:0] status, [8:2] slot_result, [15:9] occupied_count,
  //         [22:16] head_slot, [23] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned IW     = $clog2(SLOTS);
  localparam int unsigned CW     = IW + 1;
  localparam int unsigned LW     = IW + 1;
  localparam int unsigned SW     = (CW > 6) ? CW : 6;
  localparam int unsigned NGRP   = (SLOTS + vsa_pkg::GROUP - 1) / vsa_pkg::GROUP;
  localparam int unsigned GRP_IW = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned FW     = GRP_IW + vsa_pkg::GROUP_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ACQ_LINK, ST_REL_READ, ST_REL_FIX,
    ST_QRY_READ, ST_QRY_FIX, ST_RESP
  } state_t;

  state_t            state;
  logic [SLOTS-1:0]  busy;
  logic [CW-1:0]     count;
  logic              head_nil;
  logic [IW-1:0]     head_idx;
  logic              tail_nil;
  logic [IW-1:0]     tail_idx;
  logic [IW-1:0]     cmd_idx;
  logic [GRP_IW-1:0] grp;
  logic [IW-1:0]     found_idx;
  logic [1:0]        res_status;
  logic              res_nil;
  logic [IW-1:0]     res_idx;

  // Request fields
  logic [1:0]    in_cmd;
  logic [5:0]    in_slot;
  logic [SW-1:0] in_wide;
  logic [IW-1:0] in_idx;
  logic          in_on_list;
  logic          accept;

  assign in_cmd     = s_axis_tdata[1:0];
  assign in_slot    = s_axis_tdata[7:2];
  assign in_wide    = SW'(in_slot);
  assign in_idx     = in_wide[IW-1:0];
  assign in_on_list = (in_wide < SW'(SLOTS)) && busy[in_idx];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Free-slot search
  vsa_pkg::scan_result_t scan;
  logic [FW-1:0]         scan_full;

  vsa_free_scan #(.SLOTS(SLOTS)) u_scan (
    .busy   (busy),
    .grp    (grp),
    .result (scan)
  );

  assign scan_full = {grp, scan.pos};

  // Link stores; the head's prev and the tail's next are never trusted
  logic          prev_we, next_we;
  logic [IW-1:0] prev_waddr, next_waddr;
  logic [LW-1:0] prev_wdata, next_wdata;
  logic [LW-1:0] prev_rd, next_rd;
  logic          is_head, is_tail;
  logic          p_nil, n_nil;
  logic [IW-1:0] p_idx, n_idx;

  assign is_head = !head_nil && (head_idx == cmd_idx);
  assign is_tail = !tail_nil && (tail_idx == cmd_idx);
  assign p_nil   = is_head || prev_rd[IW];
  assign n_nil   = is_tail || next_rd[IW];
  assign p_idx   = prev_rd[IW-1:0];
  assign n_idx   = next_rd[IW-1:0];

  always_comb begin
    prev_we    = 1'b0;
    next_we    = 1'b0;
    prev_waddr = n_idx;
    next_waddr = p_idx;
    prev_wdata = {p_nil, p_idx};
    next_wdata = {n_nil, n_idx};
    case (state)
      ST_ACQ_LINK: begin
        prev_we    = 1'b1;
        prev_waddr = found_idx;
        prev_wdata = {tail_nil, tail_idx};
        next_we    = !tail_nil;
        next_waddr = tail_idx;
        next_wdata = {1'b0, found_idx};
      end
      ST_REL_FIX: begin
        prev_we = !n_nil;
        next_we = !p_nil;
      end
      default: begin
      end
    endcase
  end

  vsa_link_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (cmd_idx),
    .rdata (prev_rd)
  );

  vsa_link_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cmd_idx),
    .rdata (next_rd)
  );

  // Result fields as seen after this step
  logic [6:0] out_slot, out_count, out_head;

  assign out_slot  = res_nil ? 7'h7F : 7'(res_idx);
  assign out_count = 7'(count);
  assign out_head  = head_nil ? 7'h7F : 7'(head_idx);

  // Sequencer, list state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= '0;
      count         <= '0;
      head_nil      <= 1'b1;
      tail_nil      <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_idx <= in_idx;
            res_nil <= 1'b1;
            res_status <= vsa_pkg::STAT_OK;
            case (in_cmd)
              vsa_pkg::CMD_ACQUIRE: begin
                if (count >= CW'(SLOTS)) begin
                  res_status <= vsa_pkg::STAT_FULL;
                  state      <= ST_RESP;
                end else begin
                  grp   <= '0;
                  state <= ST_SCAN;
                end
              end
              vsa_pkg::CMD_RELEASE, vsa_pkg::CMD_QUERY: begin
                if (count == '0) begin
                  res_status <= vsa_pkg::STAT_EMPTY;
                  state      <= ST_RESP;
                end else if (!in_on_list) begin
                  res_status <= vsa_pkg::STAT_NOT_ON_LIST;
                  state      <= ST_RESP;
                end else if (in_cmd == vsa_pkg::CMD_RELEASE) begin
                  state <= ST_REL_READ;
                end else begin
                  state <= ST_QRY_READ;
                end
              end
              default: begin
                busy     <= '0;
                count    <= '0;
                head_nil <= 1'b1;
                tail_nil <= 1'b1;
                state    <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan.found) begin
            found_idx <= scan_full[IW-1:0];
            state     <= ST_ACQ_LINK;
          end else if (grp == GRP_IW'(NGRP - 1)) begin
            res_status <= vsa_pkg::STAT_FULL;
            state      <= ST_RESP;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        ST_ACQ_LINK: begin
          busy[found_idx] <= 1'b1;
          count           <= count + 1'b1;
          tail_nil        <= 1'b0;
          tail_idx        <= found_idx;
          if (tail_nil) begin
            head_nil <= 1'b0;
            head_idx <= found_idx;
          end
          res_nil <= 1'b0;
          res_idx <= found_idx;
          state   <= ST_RESP;
        end
        ST_REL_READ: begin
          state <= ST_REL_FIX;
        end
        ST_REL_FIX: begin
          if (p_nil) begin
            head_nil <= n_nil;
            head_idx <= n_idx;
          end
          if (n_nil) begin
            tail_nil <= p_nil;
            tail_idx <= p_idx;
          end
          busy[cmd_idx] <= 1'b0;
          count         <= count - 1'b1;
          state         <= ST_RESP;
        end
        ST_QRY_READ: begin
          state <= ST_QRY_FIX;
        end
        ST_QRY_FIX: begin
          res_nil <= n_nil;
          res_idx <= n_idx;
          state   <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, out_head, out_count, out_slot, res_status};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Occupied count never passes the pool size
  assert property (@(posedge clk) disable iff (rst) count <= CW'(SLOTS))
    else $error("occupied count above pool size");

  // Empty list exactly when nothing is occupied
  assert property (@(posedge clk) disable iff (rst) head_nil == (count == '0))
    else $error("head does not agree with occupied count");

  // Head and tail empty together
  assert property (@(posedge clk) disable iff (rst) head_nil == tail_nil)
    else $error("head and tail disagree on empty list");

  // A found slot is always free when it is taken
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACQ_LINK) |-> !busy[found_idx])
    else $error("acquire picked a busy slot");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the voice slot allocator against a cycle-free predictor of the slot
// pool and its acquisition-ordered list. Directed requests cover the empty,
// sole-element, head, middle, tail, not-on-list and clear cases; random
// phases then fill the pool to full, drain it and mix requests, with bursts
// of idling on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT   = 64;
  localparam int RANDOM_REQS  = 850;
  localparam int QUIET_REQS   = 120;
  localparam int IDLE_LIMIT   = 2000;

  typedef logic signed [6:0] link_t;
  localparam link_t NO_LINK = -7'sd1;

  typedef struct {
    logic [1:0] status;
    link_t      slot_res;
    logic [6:0] occupied;
    link_t      head;
  } slot_result_t;

  typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_kind_t;

  // Predicts each result from its request and checks results in order
  class slot_list_checker;
    bit           busy[SLOT_COUNT];
    link_t        prev_l[SLOT_COUNT];
    link_t        next_l[SLOT_COUNT];
    link_t        head;
    link_t        tail;
    int unsigned  count;
    slot_result_t awaited_results[$];
    int           errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        busy[i]   = 1'b0;
        prev_l[i] = NO_LINK;
        next_l[i] = NO_LINK;
      end
      head  = NO_LINK;
      tail  = NO_LINK;
      count = 0;
    endfunction

    // Apply one accepted request and queue the result it should produce
    function void note_request(logic [1:0] cmd, logic [5:0] slot);
      slot_result_t r;
      int           found;
      link_t        p;
      link_t        n;
      r.status   = vsa_pkg::STAT_OK;
      r.slot_res = NO_LINK;
      case (cmd)
        vsa_pkg::CMD_ACQUIRE: begin
          found = -1;
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy[i]) found = i;
          end
          if (count >= SLOT_COUNT || found < 0) begin
            r.status = vsa_pkg::STAT_FULL;
          end else begin
            busy[found]   = 1'b1;
            prev_l[found] = tail;
            next_l[found] = NO_LINK;
            if (tail != NO_LINK) next_l[int'(tail)] = link_t'(found);
            else head = link_t'(found);
            tail = link_t'(found);
            count++;
            r.slot_res = link_t'(found);
          end
        end
        vsa_pkg::CMD_RELEASE: begin
          if (count == 0) begin
            r.status = vsa_pkg::STAT_EMPTY;
          end else if (!busy[slot]) begin
            r.status = vsa_pkg::STAT_NOT_ON_LIST;
          end else begin
            p = prev_l[slot];
            n = next_l[slot];
            if (p != NO_LINK) next_l[int'(p)] = n;
            else head = n;
            if (n != NO_LINK) prev_l[int'(n)] = p;
            else tail = p;
            prev_l[slot] = NO_LINK;
            next_l[slot] = NO_LINK;
            busy[slot]   = 1'b0;
            count--;
          end
        end
        vsa_pkg::CMD_QUERY: begin
          if (count == 0) r.status = vsa_pkg::STAT_EMPTY;
          else if (!busy[slot]) r.status = vsa_pkg::STAT_NOT_ON_LIST;
          else r.slot_res = next_l[slot];
        end
        default: wipe();
      endcase
      r.occupied = count[6:0];
      r.head     = head;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data);
      slot_result_t e;
      if (awaited_results.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, data);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      compare_field("status", e.status, data[1:0]);
      compare_field("slot_result", e.slot_res, $signed(data[8:2]));
      compare_field("occupied_count", e.occupied, data[15:9]);
      compare_field("head_slot", e.head, $signed(data[22:16]));
      compare_field("pad", 0, data[23]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  slot_list_checker sb;
  bit               gaps_on;
  bit               stalls_on;
  int               stall_left;
  int               idle_cycles;

  voice_slot_allocator_ordered_list_unit #(.SLOTS(SLOT_COUNT)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 6) == 0) begin
      stall_left    <= $urandom_range(1, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one request, with an optional idle burst ahead of it
  task automatic send_request(logic [1:0] cmd, logic [5:0] slot);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {slot, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(cmd, slot);
  endtask

  // Mostly an occupied slot, otherwise any slot
  function automatic logic [5:0] pick_slot();
    logic [5:0] s;
    s = 6'($urandom_range(0, SLOT_COUNT - 1));
    if (sb.count != 0 && $urandom_range(0, 3) != 0) begin
      while (!sb.busy[s]) s = 6'($urandom_range(0, SLOT_COUNT - 1));
    end
    return s;
  endfunction

  initial begin
    run_kind_t  kind;
    int         run_left;
    int         r;
    logic [1:0] cmd;

    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, sole element, head/middle/tail unlinking
    send_request(vsa_pkg::CMD_RELEASE, 6'd0);
    send_request(vsa_pkg::CMD_QUERY, 6'd63);
    send_request(vsa_pkg::CMD_ACQUIRE, 6'd63);
    send_request(vsa_pkg::CMD_QUERY, 6'd0);
    send_request(vsa_pkg::CMD_RELEASE, 6'd0);
    send_request(vsa_pkg::CMD_QUERY, 6'd0);
    repeat (4) send_request(vsa_pkg::CMD_ACQUIRE, 6'd0);
    send_request(vsa_pkg::CMD_QUERY, 6'd0);
    send_request(vsa_pkg::CMD_QUERY, 6'd63);
    send_request(vsa_pkg::CMD_RELEASE, 6'd63);
    send_request(vsa_pkg::CMD_RELEASE, 6'd1);
    send_request(vsa_pkg::CMD_RELEASE, 6'd0);
    send_request(vsa_pkg::CMD_RELEASE, 6'd3);
    send_request(vsa_pkg::CMD_QUERY, 6'd2);
    send_request(vsa_pkg::CMD_ACQUIRE, 6'd42);
    send_request(vsa_pkg::CMD_QUERY, 6'd2);
    send_request(vsa_pkg::CMD_CLEAR, 6'd21);
    send_request(vsa_pkg::CMD_CLEAR, 6'd0);
    send_request(vsa_pkg::CMD_ACQUIRE, 6'd0);

    // Random: runs that fill the pool, drain it, or mix requests
    kind     = RUN_FILL;
    run_left = 130;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (run_left == 0) begin
        kind      = run_kind_t'($urandom_range(0, 2));
        run_left  = $urandom_range(40, 130);
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      run_left--;
      if (i >= RANDOM_REQS - QUIET_REQS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      r = $urandom_range(0, 99);
      case (kind)
        RUN_FILL:  cmd = (r < 82) ? vsa_pkg::CMD_ACQUIRE :
                         (r < 88) ? vsa_pkg::CMD_RELEASE : vsa_pkg::CMD_QUERY;
        RUN_DRAIN: cmd = (r < 15) ? vsa_pkg::CMD_ACQUIRE :
                         (r < 75) ? vsa_pkg::CMD_RELEASE : vsa_pkg::CMD_QUERY;
        default:   cmd = (r < 40) ? vsa_pkg::CMD_ACQUIRE :
                         (r < 70) ? vsa_pkg::CMD_RELEASE :
                         (r < 97) ? vsa_pkg::CMD_QUERY : vsa_pkg::CMD_CLEAR;
      endcase
      send_request(cmd, pick_slot());
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow for a late spurious one
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
